@@ rtl/homogeneous_point_transform_core_defines.svh @@
// assertion macros shared by the transform rtl
`ifndef HOMOGENEOUS_POINT_TRANSFORM_CORE_DEFINES_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_CORE_DEFINES_SVH

// condition implies consequence in the same cycle
`define HPTC_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define HPTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/hptc_pkg.sv @@
`timescale 1ns / 1ps
package hptc_pkg;

  localparam int unsigned CW   = 32;       // coordinate and coefficient width
  localparam int unsigned PW   = 2 * CW;   // product width
  localparam int unsigned SW   = PW + 2;   // row sum width
  localparam int unsigned FRAC = 16;       // fraction bits
  localparam int unsigned VW   = SW - FRAC; // shifted row value width
  localparam int unsigned MW   = VW - 1;   // magnitude width
  localparam int unsigned QW   = 32;       // quotient bits
  localparam int unsigned NREG = 8;
  localparam int unsigned IDXW = 4;
  localparam int unsigned RW   = 64;

  localparam logic [RW-1:0] MAT_RST [NREG] = '{
    64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
  };

  // payload of one divider stage, three lanes sharing one divisor
  typedef struct packed {
    logic [2:0][MW-1:0] rem;
    logic [2:0][QW-1:0] quo;
    logic [2:0]         ovf;
    logic [2:0]         neg;
    logic [2:0][VW-1:0] val;
    logic [MW-1:0]      den;
    logic               wzero;
    logic               lin;
  } div_t;

  // one restoring division step on all three lanes
  function automatic div_t div_step(div_t s);
    div_t       r;
    logic [MW:0] t;
    logic        ge;
    r = s;
    for (int k = 0; k < 3; k++) begin
      t  = {s.rem[k], s.quo[k][QW-1]};
      ge = (t >= {1'b0, s.den});
      r.rem[k] = ge ? MW'(t - {1'b0, s.den}) : t[MW-1:0];
      r.quo[k] = {s.quo[k][QW-2:0], ge};
    end
    return r;
  endfunction

endpackage

@@ rtl/homogeneous_point_transform_core.sv @@
// Homogeneous 4x4 point transform in signed Q16.16: takes one point per clock when not
// stalled and, in full mode, applies the whole matrix with translation and divides x, y
// and z by w (truncated toward zero, undivided values and w_was_zero when w is zero); in
// linear mode only the 3x3 part is applied. Results saturate to 32 bits. Throughput is
// one point per unstalled cycle. Pipeline: input register, product, two adder stages,
// sign preparation, 32-step restoring divider, output register. The matrix must be written
// through the cfg port only while no points are in flight; the block does not enforce it.
`timescale 1ns / 1ps
`include "homogeneous_point_transform_core_defines.svh"
module homogeneous_point_transform_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [hptc_pkg::IDXW-1:0]  cfg_idx_i,
  input  logic [hptc_pkg::RW-1:0]    cfg_wdata_i,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [95:0]                s_axis_tdata_i,  // point_x, point_y, point_z
  input  logic                       s_axis_tuser_i,  // action
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [95:0]                m_axis_tdata_o,  // result_x, result_y, result_z
  output logic [1:0]                 m_axis_tuser_o   // w_was_zero, saturated
);

  localparam int unsigned CW = hptc_pkg::CW;
  localparam int unsigned PW = hptc_pkg::PW;
  localparam int unsigned SW = hptc_pkg::SW;
  localparam int unsigned VW = hptc_pkg::VW;
  localparam int unsigned MW = hptc_pkg::MW;
  localparam int unsigned QW = hptc_pkg::QW;
  localparam int unsigned FRAC = hptc_pkg::FRAC;
  localparam int unsigned XW = VW + 1;
  localparam logic [hptc_pkg::IDXW-1:0] IDXW_NREG = hptc_pkg::IDXW'(hptc_pkg::NREG);

  // matrix registers
  logic [hptc_pkg::RW-1:0] mat_q [hptc_pkg::NREG];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < hptc_pkg::NREG; i++) mat_q[i] <= hptc_pkg::MAT_RST[i];
    end else if (cfg_we_i && cfg_idx_i < IDXW_NREG) begin
      mat_q[cfg_idx_i[2:0]] <= cfg_wdata_i;
    end
  end

  // global advance: whole pipe moves unless the output holds a waiting result
  logic adv;
  assign adv = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // stage 0: input register
  logic in_vld_q, in_lin_q;
  logic signed [CW-1:0] pt_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_vld_q <= 1'b0;
    else if (adv) in_vld_q <= s_axis_tvalid_i;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_lin_q <= s_axis_tuser_i;
      for (int c = 0; c < 3; c++) pt_q[c] <= $signed(s_axis_tdata_i[CW*c +: CW]);
    end
  end

  // stage 1: twelve products
  logic prd_vld_q, prd_lin_q;
  logic signed [PW-1:0] prd_q [4][3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) prd_vld_q <= 1'b0;
    else if (adv) prd_vld_q <= in_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      prd_lin_q <= in_lin_q;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          prd_q[r][c] <= $signed(mat_q[2*r + c/2][CW*(c%2) +: CW]) * pt_q[c];
        end
      end
    end
  end

  // stage 2: partial sums, translation scaled to the product format
  logic ps_vld_q, ps_lin_q;
  logic signed [SW-1:0] psa_q [4];
  logic signed [SW-1:0] psb_q [4];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ps_vld_q <= 1'b0;
    else if (adv) ps_vld_q <= prd_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ps_lin_q <= prd_lin_q;
      for (int r = 0; r < 4; r++) begin
        psa_q[r] <= SW'(prd_q[r][0]) + SW'(prd_q[r][1]);
        psb_q[r] <= SW'(prd_q[r][2]) +
                    (prd_lin_q ? '0
                               : SW'($signed({mat_q[2*r+1][CW +: CW], {FRAC{1'b0}}})));
      end
    end
  end

  // stage 3: full row sums shifted back to signed Q34.16
  logic val_vld_q, val_lin_q;
  logic signed [VW-1:0] val_q [4];
  logic signed [SW-1:0] row_sum [4];
  always_comb begin
    for (int r = 0; r < 4; r++) row_sum[r] = psa_q[r] + psb_q[r];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) val_vld_q <= 1'b0;
    else if (adv) val_vld_q <= ps_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      val_lin_q <= ps_lin_q;
      for (int r = 0; r < 4; r++) val_q[r] <= row_sum[r][SW-1:FRAC];
    end
  end

  // stage 4: magnitudes, signs, overflow check and divider setup
  hptc_pkg::div_t dv_q [QW+1];
  logic [QW:0]    dv_vld_q;
  hptc_pkg::div_t prep;
  logic [VW-1:0]  abs_w;
  logic [VW-1:0]  abs_v;
  always_comb begin
    prep  = '0;
    abs_w = val_q[3][VW-1] ? VW'(-val_q[3]) : VW'(val_q[3]);
    prep.den   = abs_w[MW-1:0];
    prep.lin   = val_lin_q;
    prep.wzero = !val_lin_q && (val_q[3] == '0);
    for (int k = 0; k < 3; k++) begin
      abs_v = val_q[k][VW-1] ? VW'(-val_q[k]) : VW'(val_q[k]);
      prep.val[k] = val_q[k];
      prep.neg[k] = val_q[k][VW-1] ^ val_q[3][VW-1];
      prep.rem[k] = {{FRAC{1'b0}}, abs_v[MW-1:FRAC]};
      prep.quo[k] = {abs_v[FRAC-1:0], {(QW-FRAC){1'b0}}};
      prep.ovf[k] = (abs_v[MW-1:FRAC] >= abs_w[MW-1:FRAC] ? 1'b0 : 1'b0) |
                    ({{FRAC{1'b0}}, abs_v[MW-1:FRAC]} >= abs_w[MW-1:0]);
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_vld_q[0] <= 1'b0;
    else if (adv) dv_vld_q[0] <= val_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) dv_q[0] <= prep;
  end

  // stages 5 to 36: one quotient bit per stage
  for (genvar i = 0; i < QW; i++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_vld_q[i+1] <= 1'b0;
      else if (adv) dv_vld_q[i+1] <= dv_vld_q[i];
    end
    always_ff @(posedge clk_i) begin
      if (adv) dv_q[i+1] <= hptc_pkg::div_step(dv_q[i]);
    end
  end

  // final select, sign and saturation
  hptc_pkg::div_t  fin;
  logic [2:0][CW-1:0] res;
  logic [2:0]      sat;
  logic signed [XW-1:0] full;
  logic [QW:0]     mag;
  logic            bypass;
  always_comb begin
    fin    = dv_q[QW];
    bypass = fin.lin || fin.wzero;
    for (int k = 0; k < 3; k++) begin
      mag  = fin.ovf[k] ? {1'b1, {QW{1'b0}}} : {1'b0, fin.quo[k]};
      full = bypass ? XW'($signed(fin.val[k]))
                    : (fin.neg[k] ? -XW'($signed({1'b0, mag})) : XW'($signed({1'b0, mag})));
      sat[k] = (full[XW-1:CW-1] != {(XW-CW+1){full[XW-1]}});
      if (!sat[k]) res[k] = full[CW-1:0];
      else if (full[XW-1]) res[k] = {1'b1, {(CW-1){1'b0}}};
      else res[k] = {1'b0, {(CW-1){1'b1}}};
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_axis_tvalid_o <= 1'b0;
    else if (adv) m_axis_tvalid_o <= dv_vld_q[QW];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_axis_tdata_o <= {res[2], res[1], res[0]};
      m_axis_tuser_o <= {|sat, fin.wzero};
    end
  end

  // checks
  `HPTC_ASSERT_NEXT(a_in_to_s0, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, in_vld_q, "accepted point did not enter stage 0")
  `HPTC_ASSERT_SAME(a_rem_lt_den, clk_i, rst_ni, dv_vld_q[QW] && !fin.lin && !fin.wzero && !fin.ovf[0], fin.rem[0] < fin.den, "divider remainder not below divisor")
  `HPTC_ASSERT_SAME(a_wzero_full, clk_i, rst_ni, dv_vld_q[QW] && fin.wzero, !fin.lin && fin.den == '0, "zero-w flag in linear mode or with nonzero w")

endmodule
